/* design/trip_energy_meter_core_macros.svh */
// assertion macros for the checker file
`ifndef TRIP_ENERGY_METER_CORE_MACROS_SVH
`define TRIP_ENERGY_METER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define TEM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tem assertion failed");

// next-cycle implication
`define TEM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tem assertion failed");

`endif

/* design/tem_pkg.sv */
// types, widths and codes shared by the trip energy meter modules
package tem_pkg;
    localparam int WINDOW  = 60;
    localparam int WIN_AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_CW  = $clog2(WINDOW + 1);
    localparam int P_W     = 20;
    localparam int S_W     = 16;
    localparam int MS_W    = 16;
    localparam int E_W     = 52;
    localparam int D_W     = 49;
    localparam int EP_W    = P_W + MS_W;
    localparam int DP_W    = S_W + MS_W;
    localparam int AVG_W   = 16;
    localparam int TEFF_W  = 17;
    localparam int NUM_W   = 59;
    localparam int Q_W     = 16;
    localparam int SUM_W   = P_W + WIN_CW;
    localparam int DVD_W   = (SUM_W > Q_W) ? SUM_W : Q_W;
    localparam int CNT_W   = $clog2(DVD_W + 1);
    localparam int ACT_W   = 2;
    localparam int CIDX_W  = 2;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 312;

    localparam logic [E_W-1:0] E_MAX    = '1;
    localparam logic [D_W-1:0] D_MAX    = '1;
    localparam logic [Q_W-1:0] EFF_MAX  = '1;
    localparam logic [E_W-1:0] TRIP_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic [E_W-1:0] TRIP_MIN = {1'b1, {(E_W-1){1'b0}}};

    typedef enum logic [ACT_W-1:0] {
        ACT_SAMPLE   = 2'd0,
        ACT_TRIP_CLR = 2'd1,
        ACT_ALL_CLR  = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SPEED_GATE = 2'd0,
        CFG_POWER_GATE = 2'd1,
        CFG_MIN_DIST   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DSEL_AVG  = 2'd0,
        DSEL_TRIP = 2'd1,
        DSEL_REC  = 2'd2
    } dsel_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_ACC   = 8'b0000_0100,
        ST_PREP  = 8'b0000_1000,
        ST_START = 8'b0001_0000,
        ST_RUN   = 8'b0010_0000,
        ST_CAP   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic  load_in;
        logic  mul;
        logic  acc;
        logic  prep;
        logic  start;
        logic  cap;
        logic  out_load;
        dsel_t sel;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } stat_t;
endpackage

/* design/tem_ram.sv */
// generic single write port ram with registered read
module tem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* design/tem_div.sv */
// restoring divider, one quotient bit per cycle
module tem_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tem_pkg::D_W-1:0]   rem_init,
    input  logic [tem_pkg::DVD_W-1:0] dvd_init,
    input  logic [tem_pkg::CNT_W-1:0] steps,
    input  logic [tem_pkg::D_W-1:0]   den,
    output logic                      busy,
    output logic [tem_pkg::DVD_W-1:0] quot
);
    import tem_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     rem_sub;
    logic             fits;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_sh - {1'b0, den};
        fits      = rem_sh >= {1'b0, den};
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        if (start) begin
            cnt_next  = steps;
            rem_next  = rem_init;
            dvd_next  = dvd_init;
            quot_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            quot_next = {quot_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;
endmodule

/* design/tem_datapath.sv */
// accumulators, power window, efficiency and mean datapath
module tem_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tem_pkg::cmd_t              cmd,
    output tem_pkg::stat_t             stat,
    input  logic [tem_pkg::ACT_W-1:0]  in_action,
    input  logic [tem_pkg::IN_W-1:0]   in_data,
    input  logic                       cfg_we,
    input  logic [tem_pkg::CIDX_W-1:0] cfg_index,
    input  logic [tem_pkg::D_W-1:0]    cfg_data,
    output logic [tem_pkg::OUT_W-1:0]  out_data
);
    import tem_pkg::*;

    // configuration
    logic [S_W-1:0]   speed_gate_reg;
    logic [P_W-2:0]   power_gate_reg;
    logic [D_W-1:0]   min_dist_reg;

    // latched item
    logic [ACT_W-1:0]    action_reg;
    logic signed [P_W-1:0] power_reg;
    logic [S_W-1:0]      speed_reg;
    logic [MS_W-1:0]     ms_reg;

    // products
    logic [EP_W-1:0] e_reg;
    logic [DP_W-1:0] d_reg;
    logic            counted_reg;
    logic [P_W-1:0]  pmag;

    // accumulators and window
    logic [E_W-1:0]  total_e_reg, regen_e_reg, trip_e_reg;
    logic [D_W-1:0]  total_d_reg, trip_d_reg;
    logic [WIN_AW-1:0] head_reg;
    logic [WIN_CW-1:0] count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [P_W-1:0]  old_pow;
    logic            win_we;

    logic [E_W:0]    te_sum, re_sum;
    logic [D_W:0]    td_sum, rd_sum;
    logic signed [E_W+1:0] trip_sum;
    logic [E_W-1:0]  trip_sat;
    logic            win_full;
    logic signed [SUM_W-1:0] sum_upd;

    // division operands
    logic [E_W-1:0]  mag;
    logic [NUM_W-1:0] num_reg;
    logic [D_W-1:0]  den_reg;
    logic [SUM_W-1:0] smag_reg;
    logic            neg_reg, en_reg, rec_reg, sat_reg;
    logic [D_W-1:0]  rem_init;
    logic [DVD_W-1:0] dvd_init;
    logic [CNT_W-1:0] steps;
    logic [DVD_W-1:0] quot;
    logic [Q_W-1:0]  q16;

    // results
    logic [AVG_W-1:0]  avg_reg;
    logic [TEFF_W-1:0] teff_reg;
    logic [P_W-1:0]    rec_out_reg;
    logic [OUT_W-1:0]  out_reg;

    assign pmag = power_reg[P_W-1] ? P_W'(-power_reg) : P_W'(power_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_gate_reg <= S_W'(10);
            power_gate_reg <= (P_W-1)'(500);
            min_dist_reg   <= D_W'(36000000);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SPEED_GATE: speed_gate_reg <= cfg_data[S_W-1:0];
                CFG_POWER_GATE: power_gate_reg <= cfg_data[P_W-2:0];
                CFG_MIN_DIST:   min_dist_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= in_action;
            power_reg  <= in_data[P_W-1:0];
            speed_reg  <= in_data[P_W+S_W-1:P_W];
            ms_reg     <= in_data[P_W+S_W+MS_W-1:P_W+S_W];
        end
        if (cmd.mul) begin
            e_reg       <= EP_W'(pmag) * EP_W'(ms_reg);
            d_reg       <= DP_W'(speed_reg) * DP_W'(ms_reg);
            counted_reg <= (action_reg == ACT_SAMPLE)
                           && ((speed_reg > speed_gate_reg) || (pmag > {1'b0, power_gate_reg}));
        end
    end

    // window of recent counted powers
    tem_ram #(.WIDTH(P_W), .DEPTH(WINDOW)) u_win (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (head_reg),
        .wdata (power_reg),
        .raddr (head_reg),
        .rdata (old_pow)
    );

    always_comb begin
        win_we   = cmd.acc && counted_reg;
        win_full = count_reg == WIN_CW'(WINDOW);
        te_sum   = {1'b0, total_e_reg} + (E_W+1)'(e_reg);
        re_sum   = {1'b0, regen_e_reg} + (E_W+1)'(e_reg);
        td_sum   = {1'b0, total_d_reg} + (D_W+1)'(d_reg);
        rd_sum   = {1'b0, trip_d_reg} + (D_W+1)'(d_reg);
        if (power_reg[P_W-1]) begin
            trip_sum = $signed({{2{trip_e_reg[E_W-1]}}, trip_e_reg})
                       - $signed((E_W+2)'(e_reg));
        end else begin
            trip_sum = $signed({{2{trip_e_reg[E_W-1]}}, trip_e_reg})
                       + $signed((E_W+2)'(e_reg));
        end
        if (trip_sum > $signed({2'b00, TRIP_MAX})) begin
            trip_sat = TRIP_MAX;
        end else if (trip_sum < $signed({2'b11, TRIP_MIN})) begin
            trip_sat = TRIP_MIN;
        end else begin
            trip_sat = trip_sum[E_W-1:0];
        end
        sum_upd = sum_reg + SUM_W'(power_reg);
        if (win_full) begin
            sum_upd = sum_upd - SUM_W'($signed(old_pow));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_e_reg <= '0;
            regen_e_reg <= '0;
            trip_e_reg  <= '0;
            total_d_reg <= '0;
            trip_d_reg  <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
        end else if (cmd.acc) begin
            if (counted_reg) begin
                if (power_reg[P_W-1]) begin
                    regen_e_reg <= re_sum[E_W] ? E_MAX : re_sum[E_W-1:0];
                end else begin
                    total_e_reg <= te_sum[E_W] ? E_MAX : te_sum[E_W-1:0];
                end
                trip_e_reg  <= trip_sat;
                total_d_reg <= td_sum[D_W] ? D_MAX : td_sum[D_W-1:0];
                trip_d_reg  <= rd_sum[D_W] ? D_MAX : rd_sum[D_W-1:0];
                sum_reg     <= sum_upd;
                if (!win_full) begin
                    count_reg <= count_reg + 1'b1;
                end
                head_reg <= (head_reg == WIN_AW'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
            end else begin
                case (action_reg)
                    ACT_TRIP_CLR: begin
                        trip_e_reg <= '0;
                        trip_d_reg <= '0;
                    end
                    ACT_ALL_CLR: begin
                        total_e_reg <= '0;
                        regen_e_reg <= '0;
                        trip_e_reg  <= '0;
                        total_d_reg <= '0;
                        trip_d_reg  <= '0;
                        head_reg    <= '0;
                        count_reg   <= '0;
                        sum_reg     <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // operand set-up for the shared divider
    assign mag = (cmd.sel == DSEL_TRIP && trip_e_reg[E_W-1]) ? -trip_e_reg
               : (cmd.sel == DSEL_TRIP) ? trip_e_reg : total_e_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            num_reg  <= NUM_W'(mag) * NUM_W'(100);
            smag_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            rec_reg  <= cmd.sel == DSEL_REC;
            unique case (cmd.sel)
                DSEL_TRIP: begin
                    den_reg <= trip_d_reg;
                    en_reg  <= trip_d_reg > min_dist_reg;
                    neg_reg <= trip_e_reg[E_W-1];
                end
                DSEL_REC: begin
                    den_reg <= D_W'(count_reg);
                    en_reg  <= count_reg != '0;
                    neg_reg <= sum_reg[SUM_W-1];
                end
                default: begin
                    den_reg <= total_d_reg;
                    en_reg  <= total_d_reg > min_dist_reg;
                    neg_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.start) begin
            sat_reg <= !rec_reg && ({6'b0, num_reg[NUM_W-1:Q_W]} >= den_reg);
        end
    end

    always_comb begin
        if (rec_reg) begin
            rem_init = '0;
            dvd_init = DVD_W'(smag_reg) << (DVD_W - SUM_W);
            steps    = CNT_W'(SUM_W);
        end else begin
            rem_init = D_W'(num_reg[NUM_W-1:Q_W]);
            dvd_init = {num_reg[Q_W-1:0], {(DVD_W-Q_W){1'b0}}};
            steps    = CNT_W'(Q_W);
        end
    end

    tem_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start),
        .rem_init (rem_init),
        .dvd_init (dvd_init),
        .steps    (steps),
        .den      (den_reg),
        .busy     (stat.div_busy),
        .quot     (quot)
    );

    assign q16 = sat_reg ? EFF_MAX : quot[Q_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            unique case (cmd.sel)
                DSEL_TRIP: teff_reg <= !en_reg ? '0
                                     : neg_reg ? -{1'b0, q16} : {1'b0, q16};
                DSEL_REC:  rec_out_reg <= !en_reg ? '0
                                        : neg_reg ? -quot[P_W-1:0] : quot[P_W-1:0];
                default:   avg_reg <= en_reg ? q16 : '0;
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= {5'b0, rec_out_reg, teff_reg, avg_reg, trip_d_reg, total_d_reg,
                        trip_e_reg, regen_e_reg, total_e_reg};
        end
    end

    assign out_data = out_reg;
endmodule

/* design/tem_ctrl.sv */
// sequencer for one item: multiply, accumulate, three divisions, output
module tem_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  tem_pkg::stat_t stat,
    output tem_pkg::cmd_t  cmd
);
    import tem_pkg::*;

    state_t state_reg, state_next;
    dsel_t  sel_reg, sel_next;
    logic   mvalid_reg, mvalid_next;

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        cmd          = '0;
        cmd.sel      = sel_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                sel_next   = DSEL_AVG;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (!stat.div_busy) begin
                    state_next = ST_CAP;
                end
            end
            ST_CAP: begin
                cmd.cap = 1'b1;
                if (sel_reg == DSEL_REC) begin
                    state_next = ST_OUT;
                end else begin
                    sel_next   = (sel_reg == DSEL_AVG) ? DSEL_TRIP : DSEL_REC;
                    state_next = ST_PREP;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sel_reg    <= DSEL_AVG;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
endmodule

/* design/trip_energy_meter_core.sv */
// top level of the trip energy meter
// usage:
//   input stream: one request per item; s_tuser holds the action (sample, clear trip,
//   clear all, none), s_tdata the power, speed and interval of a sample.
//   output stream: one request per input item carrying all accumulators, the two
//   efficiencies in Wh/km and the mean power over the window of counted samples.
//   configuration: cfg_valid with cfg_index/cfg_data writes the gates and the
//   minimum distance; cfg_ready is high out of reset, writes belong to idle periods.
// sequence:
//   an item is multiplied and accumulated, then passes three divisions on the
//   single bit-serial divider that does the two efficiency divisions and the
//   window mean one after the other, before its result is loaded for output.
//   one item is in work at a time; the next is accepted only after that load.
// reset (aresetn low, synchronous): accumulators and window are cleared, the
//   registers return to their defaults and no result is pending.
// stall: a finished result waits in the output register; the next item is taken
//   and worked on meanwhile, and its result waits until the earlier one is taken.
module trip_energy_meter_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // power_w[19:0], speed_centi_kmh[35:20], interval_ms[51:36], zero pad
    input  logic [tem_pkg::IN_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [tem_pkg::ACT_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // total_energy[51:0], regen_energy[103:52], trip_energy[155:104],
    // total_distance[204:156], trip_distance[253:205], average_wh_per_km[269:254],
    // trip_wh_per_km[286:270], recent_power_w[306:287], zero pad
    output logic [tem_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tem_pkg::CIDX_W-1:0] cfg_index,
    input  logic [tem_pkg::D_W-1:0]    cfg_data
);
    import tem_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = aresetn;

    tem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tem_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );
endmodule

/* design/tem_checker.sv */
// port-level checks for the trip energy meter, bound to the top level
`include "trip_energy_meter_core_macros.svh"

module tem_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [tem_pkg::OUT_W-1:0] m_tdata
);
    // one item in work at a time
    `TEM_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result never follows its request in the next cycle
    `TEM_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))
    // a stalled result holds
    `TEM_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))
endmodule

bind trip_energy_meter_core tem_checker u_tem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/trip_energy_meter_core_tb.sv */
// testbench for the trip energy meter core: directed and random streams checked against a predictor
`timescale 1ns / 100ps

class meter_scoreboard;
    // configuration and accumulator state mirrored from the block
    logic [15:0]        spd_gate;
    logic [18:0]        pwr_gate;
    logic [48:0]        min_dist;
    logic [51:0]        tot_e, regen_e;
    logic signed [51:0] trip_e;
    logic [48:0]        tot_d, trip_d;
    logic signed [19:0] win [60];
    int                 win_head, win_count;
    longint             win_sum;
    logic [311:0]       pending [$];
    int                 errors;

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        spd_gate = 16'd10;
        pwr_gate = 19'd500;
        min_dist = 49'd36000000;
        clear_all();
    endfunction

    function void clear_all();
        tot_e = '0;
        regen_e = '0;
        trip_e = '0;
        tot_d = '0;
        trip_d = '0;
        win_head = 0;
        win_count = 0;
        win_sum = 0;
    endfunction

    function void write_reg(tem_pkg::cfg_idx_t idx, logic [48:0] val);
        case (idx)
            tem_pkg::CFG_SPEED_GATE: spd_gate = val[15:0];
            tem_pkg::CFG_POWER_GATE: pwr_gate = val[18:0];
            tem_pkg::CFG_MIN_DIST:   min_dist = val;
            default: ;
        endcase
    endfunction

    function longint eff_mag(longint mag, longint dst);
        longint q;
        q = (mag * 100) / dst;
        return (q > 65535) ? 65535 : q;
    endfunction

    function void note_request(tem_pkg::action_t act, logic signed [19:0] pw,
                               logic [15:0] spd, logic [15:0] ms);
        longint pmag, e, d, s, avg, teff, rec, mag;
        logic [311:0] r;
        pmag = (pw < 0) ? -longint'(pw) : longint'(pw);
        case (act)
            tem_pkg::ACT_SAMPLE: begin
                if (spd > spd_gate || pmag > pwr_gate) begin
                    e = pmag * ms;
                    d = longint'(spd) * ms;
                    if (pw >= 0) begin
                        s = longint'(tot_e) + e;
                        tot_e = (s > 64'hFFFFFFFFFFFFF) ? '1 : s[51:0];
                        s = longint'(trip_e) + e;
                    end else begin
                        s = longint'(regen_e) + e;
                        regen_e = (s > 64'hFFFFFFFFFFFFF) ? '1 : s[51:0];
                        s = longint'(trip_e) - e;
                    end
                    if (s > 64'sh7FFFFFFFFFFFF) s = 64'sh7FFFFFFFFFFFF;
                    if (s < -64'sh8000000000000) s = -64'sh8000000000000;
                    trip_e = s[51:0];
                    s = longint'(tot_d) + d;
                    tot_d = (s > 64'h1FFFFFFFFFFFF) ? '1 : s[48:0];
                    s = longint'(trip_d) + d;
                    trip_d = (s > 64'h1FFFFFFFFFFFF) ? '1 : s[48:0];
                    if (win_count >= 60) win_sum -= win[win_head];
                    else win_count++;
                    win[win_head] = pw;
                    win_sum += pw;
                    win_head = (win_head + 1) % 60;
                end
            end
            tem_pkg::ACT_TRIP_CLR: begin
                trip_e = '0;
                trip_d = '0;
            end
            tem_pkg::ACT_ALL_CLR: clear_all();
            default: ;
        endcase
        avg = (tot_d > min_dist) ? eff_mag(longint'(tot_e), longint'(tot_d)) : 0;
        teff = 0;
        if (trip_d > min_dist) begin
            mag = (trip_e < 0) ? -longint'(trip_e) : longint'(trip_e);
            teff = eff_mag(mag, longint'(trip_d));
            if (trip_e < 0) teff = -teff;
        end
        rec = (win_count > 0) ? win_sum / win_count : 0;
        r = '0;
        r[51:0] = tot_e;
        r[103:52] = regen_e;
        r[155:104] = trip_e;
        r[204:156] = tot_d;
        r[253:205] = trip_d;
        r[269:254] = avg[15:0];
        r[286:270] = teff[16:0];
        r[306:287] = rec[19:0];
        pending.push_back(r);
    endfunction

    function void check_result(logic [311:0] got);
        logic [311:0] want;
        if (pending.size() == 0) begin
            $error("result with nothing expected: %h", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[51:0] !== want[51:0]) begin
            $error("total_energy exp %0d got %0d", want[51:0], got[51:0]); errors++;
        end
        if (got[103:52] !== want[103:52]) begin
            $error("regen_energy exp %0d got %0d", want[103:52], got[103:52]); errors++;
        end
        if (got[155:104] !== want[155:104]) begin
            $error("trip_energy exp %0d got %0d", $signed(want[155:104]),
                   $signed(got[155:104])); errors++;
        end
        if (got[204:156] !== want[204:156]) begin
            $error("total_distance exp %0d got %0d", want[204:156], got[204:156]); errors++;
        end
        if (got[253:205] !== want[253:205]) begin
            $error("trip_distance exp %0d got %0d", want[253:205], got[253:205]); errors++;
        end
        if (got[269:254] !== want[269:254]) begin
            $error("average_wh_per_km exp %0d got %0d", want[269:254], got[269:254]);
            errors++;
        end
        if (got[286:270] !== want[286:270]) begin
            $error("trip_wh_per_km exp %0d got %0d", $signed(want[286:270]),
                   $signed(got[286:270])); errors++;
        end
        if (got[306:287] !== want[306:287]) begin
            $error("recent_power_w exp %0d got %0d", $signed(want[306:287]),
                   $signed(got[306:287])); errors++;
        end
    endfunction
endclass

module trip_energy_meter_core_tb;
    import tem_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [ACT_W-1:0]  s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [D_W-1:0]    cfg_data = '0;

    meter_scoreboard   meter = new();
    bit                calm = 0;
    bit                hold_sink = 0;
    longint            cycles = 0;

    trip_energy_meter_core u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("trip_energy_meter_core test failed");
            $finish;
        end
    end

    // sink: checks on rising edge, varies ready on falling edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) meter.check_result(m_tdata);
    end

    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 0;
                repeat (3000) @(negedge aclk);
                hold_sink = 0;
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 18);
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    // valid stays high after a request until the next call or drain updates it
    task automatic send_request(action_t act, logic signed [19:0] pw,
                                logic [15:0] spd, logic [15:0] ms);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tuser <= act;
        s_tdata <= {4'b0, ms, spd, pw};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        meter.note_request(act, pw, spd, ms);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [D_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        meter.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (meter.pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic random_request(int big);
        action_t act;
        logic signed [19:0] pw;
        logic [15:0] spd, ms;
        int r;
        r = $urandom_range(0, 99);
        act = (r < 90) ? ACT_SAMPLE : (r < 95) ? ACT_TRIP_CLR : (r < 98) ? ACT_ALL_CLR
                                                                        : ACT_NONE;
        pw = 20'($signed($urandom_range(0, 600000)) - 300000);
        if ($urandom_range(0, 9) == 0) pw = 20'($urandom()); // raw bit patterns now and then
        spd = 16'($urandom_range(0, 50000));
        if ($urandom_range(0, 9) == 0) spd = 16'($urandom());
        ms = big ? 16'($urandom()) : 16'($urandom_range(0, 400));
        if ($urandom_range(0, 7) == 0) ms = 0;
        send_request(act, pw, spd, ms);
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: field extremes, every action, gate edges, a run of samples after a clear
        send_request(ACT_SAMPLE, 20'sd300000, 16'd50000, 16'd65535);
        send_request(ACT_SAMPLE, -20'sd300000, 16'd50000, 16'd65535);
        send_request(ACT_SAMPLE, 20'sd0, 16'd11, 16'd100);
        send_request(ACT_SAMPLE, 20'sd0, 16'd10, 16'd100);
        send_request(ACT_SAMPLE, 20'sd501, 16'd0, 16'd0);
        send_request(ACT_SAMPLE, -20'sd500, 16'd0, 16'd100);
        send_request(ACT_NONE, 20'sd1234, 16'd5000, 16'd10);
        send_request(ACT_TRIP_CLR, -20'sd1, 16'hFFFF, 16'hFFFF);
        send_request(ACT_SAMPLE, -20'sd524288, 16'hFFFF, 16'hFFFF);
        send_request(ACT_SAMPLE, 20'sd524287, 16'hFFFF, 16'hFFFF);
        send_request(ACT_ALL_CLR, 20'sd5, 16'd5, 16'd5);
        for (int i = 0; i < 12; i++) send_request(ACT_SAMPLE, 20'(-1000 - i), 16'd200, 16'd1);
        drain();

        // settings sweep including extremes; the first phase uses zero gates and long intervals
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_SPEED_GATE, D_W'(0));
                    write_reg(CFG_POWER_GATE, D_W'(0));
                    write_reg(CFG_MIN_DIST, D_W'(0));
                end
                1: begin
                    write_reg(CFG_SPEED_GATE, D_W'(50000));
                    write_reg(CFG_POWER_GATE, D_W'(300000));
                    write_reg(CFG_MIN_DIST, 49'h1FFFFFFFFFFFF);
                end
                2: begin
                    write_reg(CFG_SPEED_GATE, D_W'(16'hFFFF));
                    write_reg(CFG_POWER_GATE, D_W'(19'h7FFFF));
                    write_reg(CFG_MIN_DIST, D_W'(1000));
                end
                3: begin
                    write_reg(CFG_SPEED_GATE, D_W'($urandom_range(0, 3000)));
                    write_reg(CFG_POWER_GATE, D_W'($urandom_range(0, 20000)));
                    write_reg(CFG_MIN_DIST, D_W'({$urandom(), $urandom()} & D_MAX));
                end
                default: begin
                    write_reg(CFG_SPEED_GATE, D_W'(10));
                    write_reg(CFG_POWER_GATE, D_W'(500));
                    write_reg(CFG_MIN_DIST, D_W'(36000000));
                end
            endcase
            if (ph == 2) hold_sink = 1;
            if (ph == 4) calm = 1;
            for (int i = 0; i < 180; i++) random_request((ph == 0) || (i % 10 == 0));
            drain();
        end

        if (meter.errors == 0 && meter.pending.size() == 0)
            $display("trip_energy_meter_core test passed");
        else
            $display("trip_energy_meter_core test failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/tem_pkg.sv
design/tem_ram.sv
design/tem_div.sv
design/tem_datapath.sv
design/tem_ctrl.sv
design/trip_energy_meter_core.sv
design/tem_checker.sv
tb/trip_energy_meter_core_tb.sv
